/* hdl/qse_pkg.sv */
package qse_pkg;

    // default store geometry
    localparam int QSE_DEPTH    = 64;
    localparam int QSE_KEY_BITS = 32;

    // width of the key ports
    localparam int KEY_PORT_W = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_POP,
        S_POP_WAIT,
        S_PIVOT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SWAP_W2,
        S_FIN_RD,
        S_FIN_W1,
        S_FIN_W2,
        S_PUSH_LO,
        S_PUSH_HI,
        S_EMIT_RD,
        S_EMIT_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_key;
        logic sort_init;
        logic pop_rd;
        logic range_start;
        logic pivot_cap;
        logic scan_rd;
        logic step_i;
        logic swap_w1;
        logic swap_w2;
        logic fin_rd;
        logic fin_w1;
        logic fin_w2;
        logic push_lo;
        logic push_hi;
        logic emit_rd;
        logic emit_load;
        logic run_clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic stack_empty;
        logic range_bad;
        logic scan_done;
        logic less;
        logic need_push_lo;
        logic need_push_hi;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

/* hdl/qse_datapath.sv */
module qse_datapath #(
    parameter int DEPTH    = qse_pkg::QSE_DEPTH,
    parameter int KEY_BITS = qse_pkg::QSE_KEY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qse_pkg::t_cmd                   i_cmd,
    output qse_pkg::t_stat                  o_stat,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,
    input  logic [qse_pkg::KEY_PORT_W-1:0]  i_key_in,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [qse_pkg::KEY_PORT_W-1:0]  o_key_out,
    output logic                            o_last_out,
    output logic                            o_overflow
);
    import qse_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W1    = IDX_W + 1;

    // key store and range stack
    logic [KEY_BITS-1:0] r_keys  [DEPTH];
    logic [2*IDX_W-1:0]  r_stack [DEPTH];

    logic                r_cmp_signed;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_sp;
    logic [CNT_W-1:0]    r_k;
    logic                r_ovf;
    logic [IDX_W-1:0]    r_lo, r_hi, r_i, r_split;
    logic [KEY_BITS-1:0] r_pivot, r_rd_a, r_rd_b;
    logic [2*IDX_W-1:0]  r_stk_rd;
    logic                r_out_valid;
    logic [KEY_PORT_W-1:0] r_out_key;
    logic                r_out_last, r_out_ovf;

    logic                store_full, stack_full;
    logic [IDX_W-1:0]    stk_lo, stk_hi, split_m1, split_p1, count_m1;
    logic [CNT_W-1:0]    sp_m1;
    logic [KEY_BITS-1:0] flip;

    logic                key_we;
    logic [IDX_W-1:0]    key_wa;
    logic [KEY_BITS-1:0] key_wd;
    logic                rd_a_en;
    logic [IDX_W-1:0]    rd_a_addr;

    logic                stk_push;
    logic [2*IDX_W-1:0]  stk_wd;

    assign store_full = (r_count == CNT_W'(DEPTH));
    assign stack_full = (r_sp == CNT_W'(DEPTH));
    assign stk_lo     = r_stk_rd[IDX_W-1:0];
    assign stk_hi     = r_stk_rd[2*IDX_W-1:IDX_W];
    assign split_m1   = r_split - IDX_W'(1);
    assign split_p1   = r_split + IDX_W'(1);
    assign count_m1   = IDX_W'(r_count - CNT_W'(1));
    assign sp_m1      = r_sp - CNT_W'(1);
    // signed order: flip the sign bit, then compare unsigned
    assign flip       = {r_cmp_signed, {(KEY_BITS-1){1'b0}}};

    // status back to the controller
    always_comb begin
        o_stat.stack_empty  = (r_sp == '0);
        o_stat.range_bad    = (CNT_W'(stk_hi) >= CNT_W'(DEPTH)) || (stk_lo >= stk_hi);
        o_stat.scan_done    = (r_i == r_hi);
        o_stat.less         = ((r_rd_a ^ flip) < (r_pivot ^ flip));
        o_stat.need_push_lo = ({1'b0, r_split} > ({1'b0, r_lo} + W1'(1)));
        o_stat.need_push_hi = (({1'b0, r_split} + W1'(1)) < {1'b0, r_hi});
        o_stat.emit_last    = ((r_k + CNT_W'(1)) == r_count);
        o_stat.out_free     = !r_out_valid || !i_out_stall;
    end

    // key store write port
    always_comb begin
        key_we = 1'b0;
        key_wa = '0;
        key_wd = '0;
        if (i_cmd.load_key && !store_full) begin
            key_we = 1'b1;
            key_wa = r_count[IDX_W-1:0];
            key_wd = KEY_BITS'(i_key_in);
        end else if (i_cmd.swap_w1) begin
            key_we = 1'b1;
            key_wa = r_split;
            key_wd = r_rd_a;
        end else if (i_cmd.swap_w2) begin
            key_we = 1'b1;
            key_wa = r_i;
            key_wd = r_rd_b;
        end else if (i_cmd.fin_w1) begin
            key_we = 1'b1;
            key_wa = r_hi;
            key_wd = r_rd_a;
        end else if (i_cmd.fin_w2) begin
            key_we = 1'b1;
            key_wa = r_split;
            key_wd = r_pivot;
        end
    end

    // key store read port a
    always_comb begin
        rd_a_en   = (i_cmd.range_start && !o_stat.range_bad) || i_cmd.scan_rd ||
                    i_cmd.fin_rd || i_cmd.emit_rd;
        rd_a_addr = r_k[IDX_W-1:0];
        if (i_cmd.range_start) begin
            rd_a_addr = stk_hi;
        end else if (i_cmd.scan_rd) begin
            rd_a_addr = r_i;
        end else if (i_cmd.fin_rd) begin
            rd_a_addr = r_split;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_keys[key_wa] <= key_wd;
        end
        if (rd_a_en) begin
            r_rd_a <= r_keys[rd_a_addr];
        end
        if (i_cmd.scan_rd) begin
            r_rd_b <= r_keys[r_split];
        end
    end

    // range stack
    always_comb begin
        stk_push = (i_cmd.sort_init && (r_count >= CNT_W'(2))) ||
                   i_cmd.push_lo || i_cmd.push_hi;
        stk_wd   = {count_m1, {IDX_W{1'b0}}};
        if (i_cmd.push_lo) begin
            stk_wd = {split_m1, r_lo};
        end else if (i_cmd.push_hi) begin
            stk_wd = {r_hi, split_p1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_push && !stack_full) begin
            r_stack[r_sp[IDX_W-1:0]] <= stk_wd;
        end
        if (i_cmd.pop_rd) begin
            r_stk_rd <= r_stack[sp_m1[IDX_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_signed <= 1'b0;
            r_count      <= '0;
            r_sp         <= '0;
            r_k          <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cmp_signed <= i_cfg_wr_data;
            end
            if (i_cmd.load_key) begin
                if (store_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.pop_rd) begin
                r_sp <= sp_m1;
            end else if (stk_push && !stack_full) begin
                r_sp <= r_sp + CNT_W'(1);
            end
            if (i_cmd.run_clear) begin
                r_k <= '0;
            end else if (i_cmd.emit_load) begin
                r_k <= r_k + CNT_W'(1);
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.run_clear) begin
                r_count <= '0;
                r_sp    <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // range bounds, scan indexes, pivot and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.range_start) begin
            r_lo    <= stk_lo;
            r_hi    <= stk_hi;
            r_i     <= stk_lo;
            r_split <= stk_lo;
        end
        if (i_cmd.pivot_cap) begin
            r_pivot <= r_rd_a;
        end
        if (i_cmd.step_i || i_cmd.swap_w2) begin
            r_i <= r_i + IDX_W'(1);
        end
        if (i_cmd.swap_w2) begin
            r_split <= split_p1;
        end
        if (i_cmd.emit_load) begin
            r_out_key  <= KEY_PORT_W'(r_rd_a);
            r_out_last <= o_stat.emit_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_out   = r_out_key;
    assign o_last_out  = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

/* hdl/qse_ctrl.sv */
module qse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last_in,
    output logic           o_stall,
    input  qse_pkg::t_stat i_stat,
    output qse_pkg::t_cmd  o_cmd
);
    import qse_pkg::*;

    t_state r_state, n_state;
    logic   in_fire;

    assign in_fire = i_valid && (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_fire && i_last_in) n_state = S_INIT;
            end
            S_INIT:     n_state = S_POP;
            S_POP: begin
                n_state = i_stat.stack_empty ? S_EMIT_RD : S_POP_WAIT;
            end
            S_POP_WAIT: begin
                n_state = i_stat.range_bad ? S_POP : S_PIVOT;
            end
            S_PIVOT:    n_state = S_SCAN_RD;
            S_SCAN_RD: begin
                n_state = i_stat.scan_done ? S_FIN_RD : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                n_state = i_stat.less ? S_SWAP_W2 : S_SCAN_RD;
            end
            S_SWAP_W2:  n_state = S_SCAN_RD;
            S_FIN_RD:   n_state = S_FIN_W1;
            S_FIN_W1:   n_state = S_FIN_W2;
            S_FIN_W2:   n_state = S_PUSH_LO;
            S_PUSH_LO:  n_state = S_PUSH_HI;
            S_PUSH_HI:  n_state = S_POP;
            S_EMIT_RD: begin
                if (i_stat.out_free) n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                n_state = i_stat.emit_last ? S_LOAD : S_EMIT_RD;
            end
            default:    n_state = S_LOAD;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_LOAD: begin
                o_stall        = 1'b0;
                o_cmd.load_key = in_fire;
            end
            S_INIT:     o_cmd.sort_init = 1'b1;
            S_POP:      o_cmd.pop_rd    = !i_stat.stack_empty;
            S_POP_WAIT: o_cmd.range_start = 1'b1;
            S_PIVOT:    o_cmd.pivot_cap = 1'b1;
            S_SCAN_RD:  o_cmd.scan_rd   = !i_stat.scan_done;
            S_SCAN_CMP: begin
                o_cmd.swap_w1 = i_stat.less;
                o_cmd.step_i  = !i_stat.less;
            end
            S_SWAP_W2:  o_cmd.swap_w2   = 1'b1;
            S_FIN_RD:   o_cmd.fin_rd    = 1'b1;
            S_FIN_W1:   o_cmd.fin_w1    = 1'b1;
            S_FIN_W2:   o_cmd.fin_w2    = 1'b1;
            S_PUSH_LO:  o_cmd.push_lo   = i_stat.need_push_lo;
            S_PUSH_HI:  o_cmd.push_hi   = i_stat.need_push_hi;
            S_EMIT_RD:  o_cmd.emit_rd   = i_stat.out_free;
            S_EMIT_LOAD: begin
                o_cmd.emit_load = 1'b1;
                o_cmd.run_clear = i_stat.emit_last;
            end
            default: begin
                o_cmd   = '0;
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

/* hdl/quicksort_engine_top.sv */
// quicksort engine: keys stream in one transaction per cycle, while loading, into a
// DEPTH-entry key store; the transaction with last_in set closes the set and
// starts an in-place quicksort (lomuto partition, last element of each range as
// pivot, pending ranges held on a range stack), during which the input is stalled.
// each range is popped and its pivot fetched, then the partition scan compares each
// key with the pivot and exchanges it when less; the scan closes, the pivot is
// swapped into place and each sub-range with more than one key is pushed; the key
// store has a single write port. sorted keys then leave one at a time, each read
// and then loaded into the output register while the output is not stalled, the
// final one with last_out set; the next set may start loading as soon as the final
// key sits in the output register. keys beyond DEPTH are dropped and every result
// of that run carries overflow. compare_signed (i_cfg_wr_data under i_cfg_wr_en)
// picks unsigned or two's complement order over the low KEY_BITS bits of each key;
// write it only while the block is idle. no clearing pass is needed after reset.
module quicksort_engine_top #(
    parameter int DEPTH    = qse_pkg::QSE_DEPTH,
    parameter int KEY_BITS = qse_pkg::QSE_KEY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    // key input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [qse_pkg::KEY_PORT_W-1:0] i_key_in,
    input  logic                           i_last_in,
    // sorted output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [qse_pkg::KEY_PORT_W-1:0] o_key_out,
    output logic                           o_last_out,
    output logic                           o_overflow
);
    import qse_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: load, partition loop, emit
    qse_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_last_in (i_last_in),
        .o_stall   (o_stall),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // key store, range stack, indexes, comparator and output register
    qse_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_key_in      (i_key_in),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_key_out     (o_key_out),
        .o_last_out    (o_last_out),
        .o_overflow    (o_overflow)
    );

endmodule
